@@ rtl/ppcf_pkg.sv @@
// ppcf_pkg: constants, types and state encoding shared by the particle pair
// contact finder. No dependencies.
`default_nettype none

package ppcf_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int FRAC_BITS     = 16;
   localparam int RESULT_CAP    = 64;

   localparam int IDX_W  = $clog2(MAX_PARTICLES);
   localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
   localparam int POS_W  = 32;
   localparam int CD_W   = 23;
   localparam int LIM_W  = 7;
   localparam int IDXO_W = 6;
   localparam int NRM_W  = 18;
   localparam int CSR_IDX_W = 1;

   // squared distance, root and remainder widths of the shared unit
   localparam int SQ_W   = 2 * CD_W + 2;
   localparam int ROOT_W = SQ_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = FRAC_BITS + 1;
   localparam int STEP_W     = $clog2(SQRT_STEPS + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_CONTACT_LIMIT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTACT_DISTANCE = 1'd1;

   localparam logic [LIM_W-1:0] LIMIT_RESET    = LIM_W'(RESULT_CAP);
   localparam logic [CD_W-1:0]  DISTANCE_RESET = CD_W'(1 << FRAC_BITS);

   typedef enum logic [0:0] {
      OP_SQRT,
      OP_DIV
   } ppcf_op_type;

   typedef struct packed {
      logic        start;
      ppcf_op_type op;
   } ppcf_unit_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RD_I,
      ST_LATCH_I,
      ST_RD_J,
      ST_CHECK,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_RANGE,
      ST_SQRT,
      ST_DIV,
      ST_FOUND,
      ST_NEXT,
      ST_FINISH
   } ppcf_state_type;

endpackage

`default_nettype wire

@@ rtl/particle_pair_contact_finder.sv @@
// particle_pair_contact_finder: top level with the pair sequencer, squaring
// multiplier and position memories. Depends on ppcf_pkg, ppcf_ram, ppcf_unit.
`default_nettype none

// Positions load at one transaction per cycle while busy is low; the
// transaction with req_last_particle set starts the pair search and busy stays
// high until the final result. Every ordered pair is rejected early if any
// axis distance reaches the contact distance, or once squared if its squared
// distance is zero or out of range; one that touches runs a 24-step square root
// then three 17-step divisions in the one shared unit. Each row first fetches
// particle i. Results appear on rsp_strobe for one cycle each and cannot be
// held off; rsp_last_contact marks the final one, which comes the cycle after
// the previous result when the limit is hit, and otherwise once the remaining
// pairs are walked. Configuration writes take effect at once and belong in idle.
module particle_pair_contact_finder (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [ppcf_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic signed [ppcf_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic signed [ppcf_pkg::POS_W-1:0]     req_pos_z,
   input  wire logic                                  req_last_particle,
   input  wire logic                                  csr_wr_en,
   input  wire logic        [ppcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic        [ppcf_pkg::CD_W-1:0]      csr_wr_data,
   output logic                                       rsp_strobe,
   output logic                                       rsp_contact_valid,
   output logic             [ppcf_pkg::IDXO_W-1:0]    rsp_first_index,
   output logic             [ppcf_pkg::IDXO_W-1:0]    rsp_second_index,
   output logic signed      [ppcf_pkg::NRM_W-1:0]     rsp_normal_x,
   output logic signed      [ppcf_pkg::NRM_W-1:0]     rsp_normal_y,
   output logic signed      [ppcf_pkg::NRM_W-1:0]     rsp_normal_z,
   output logic             [ppcf_pkg::CD_W-1:0]      rsp_penetration_depth,
   output logic                                       rsp_last_contact
);

   localparam logic [ppcf_pkg::ROOT_W-1:0] ONE = ppcf_pkg::ROOT_W'(1 << ppcf_pkg::FRAC_BITS);

   ppcf_pkg::ppcf_state_type state_ff, state_in;

   logic [ppcf_pkg::LIM_W-1:0]  limit_ff, limit_in;
   logic [ppcf_pkg::CD_W-1:0]   cd_ff, cd_in;
   logic [ppcf_pkg::CNT_W-1:0]  loaded_ff, loaded_in;
   logic [ppcf_pkg::LIM_W-1:0]  lim_ff, lim_in;
   logic [ppcf_pkg::LIM_W-1:0]  emitted_ff, emitted_in;
   logic [ppcf_pkg::IDX_W-1:0]  i_ff, i_in;
   logic [ppcf_pkg::IDX_W-1:0]  j_ff, j_in;
   logic [1:0]                  axis_ff, axis_in;
   logic [ppcf_pkg::POS_W-1:0]  pix_ff, pix_in, piy_ff, piy_in, piz_ff, piz_in;
   logic [ppcf_pkg::CD_W-1:0]   ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [2:0]                  neg_ff, neg_in;
   logic [ppcf_pkg::SQ_W-2:0]   cdsq_ff, cdsq_in;
   logic [ppcf_pkg::SQ_W-1:0]   acc_ff, acc_in;
   logic [ppcf_pkg::ROOT_W-1:0] len_ff, len_in;
   logic [ppcf_pkg::NRM_W-1:0]  nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;

   // contact held back until it is known whether it is the last one
   logic                        pend_v_ff, pend_v_in;
   logic [ppcf_pkg::IDXO_W-1:0] pend_i_ff, pend_i_in, pend_j_ff, pend_j_in;
   logic [ppcf_pkg::NRM_W-1:0]  pend_nx_ff, pend_nx_in, pend_ny_ff, pend_ny_in;
   logic [ppcf_pkg::NRM_W-1:0]  pend_nz_ff, pend_nz_in;
   logic [ppcf_pkg::CD_W-1:0]   pend_pen_ff, pend_pen_in;

   logic                        emit, emit_last;

   logic                        wr_en, rd_en;
   logic [ppcf_pkg::IDX_W-1:0]  wr_addr, rd_addr;
   logic [ppcf_pkg::POS_W-1:0]  qx, qy, qz;

   logic [ppcf_pkg::CD_W-1:0]     mul_a, mul_b;
   logic [2*ppcf_pkg::CD_W-1:0]   prod;

   ppcf_pkg::ppcf_unit_cmd_type   ucmd;
   logic [ppcf_pkg::CD_W-1:0]     u_dividend;
   logic [ppcf_pkg::ROOT_W-1:0]   u_divisor;
   logic                          u_done;
   logic [ppcf_pkg::ROOT_W-1:0]   u_result;
   logic [1:0]                    div_axis;

   logic signed [ppcf_pkg::POS_W:0] dx, dy, dz;
   logic [ppcf_pkg::POS_W:0]        abx, aby, abz;
   logic [ppcf_pkg::ROOT_W-1:0]     qsat;
   logic [ppcf_pkg::NRM_W-1:0]      nrm;
   logic                            last_i, last_j;

   ppcf_ram #(.WIDTH(ppcf_pkg::POS_W), .DEPTH(ppcf_pkg::MAX_PARTICLES)) u_ram_x (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_pos_x),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(qx));
   ppcf_ram #(.WIDTH(ppcf_pkg::POS_W), .DEPTH(ppcf_pkg::MAX_PARTICLES)) u_ram_y (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_pos_y),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(qy));
   ppcf_ram #(.WIDTH(ppcf_pkg::POS_W), .DEPTH(ppcf_pkg::MAX_PARTICLES)) u_ram_z (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(req_pos_z),
      .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(qz));

   ppcf_unit u_unit (
      .clock(clock), .reset(reset), .cmd(ucmd), .radicand(acc_ff),
      .dividend(u_dividend), .divisor(u_divisor), .done(u_done), .result(u_result));

   assign busy    = (state_ff != ppcf_pkg::ST_IDLE);
   assign wr_en   = (state_ff == ppcf_pkg::ST_IDLE) && start &&
                    (loaded_ff < ppcf_pkg::CNT_W'(ppcf_pkg::MAX_PARTICLES));
   assign wr_addr = loaded_ff[ppcf_pkg::IDX_W-1:0];
   assign rd_en   = (state_ff == ppcf_pkg::ST_RD_I) || (state_ff == ppcf_pkg::ST_RD_J);
   assign rd_addr = (state_ff == ppcf_pkg::ST_RD_I) ? i_ff : j_ff;

   assign prod = mul_a * mul_b;

   assign dx  = $signed({pix_ff[ppcf_pkg::POS_W-1], pix_ff}) - $signed({qx[ppcf_pkg::POS_W-1], qx});
   assign dy  = $signed({piy_ff[ppcf_pkg::POS_W-1], piy_ff}) - $signed({qy[ppcf_pkg::POS_W-1], qy});
   assign dz  = $signed({piz_ff[ppcf_pkg::POS_W-1], piz_ff}) - $signed({qz[ppcf_pkg::POS_W-1], qz});
   assign abx = dx[ppcf_pkg::POS_W] ? (ppcf_pkg::POS_W+1)'(0) - dx : dx;
   assign aby = dy[ppcf_pkg::POS_W] ? (ppcf_pkg::POS_W+1)'(0) - dy : dy;
   assign abz = dz[ppcf_pkg::POS_W] ? (ppcf_pkg::POS_W+1)'(0) - dz : dz;

   assign last_i = ({1'b0, i_ff} + 1'b1) == ppcf_pkg::CNT_W'(loaded_ff);
   assign last_j = ({1'b0, j_ff} + 1'b1) == ppcf_pkg::CNT_W'(loaded_ff);

   assign div_axis = (state_ff == ppcf_pkg::ST_SQRT) ? 2'd0 : axis_ff + 2'd1;
   assign u_divisor = (state_ff == ppcf_pkg::ST_SQRT) ? u_result : len_ff;

   always_comb begin
      case (div_axis)
         2'd0:    u_dividend = ax_ff;
         2'd1:    u_dividend = ay_ff;
         default: u_dividend = az_ff;
      endcase
   end

   // saturated, signed normal component from the divider result
   always_comb begin
      qsat = (u_result > ONE) ? ONE : u_result;
      if (neg_ff[axis_ff]) begin
         nrm = ppcf_pkg::NRM_W'(ppcf_pkg::ROOT_W'(0) - qsat);
      end else begin
         nrm = ppcf_pkg::NRM_W'(qsat);
      end
   end

   always_comb begin
      state_in    = state_ff;
      limit_in    = limit_ff;
      cd_in       = cd_ff;
      loaded_in   = loaded_ff;
      lim_in      = lim_ff;
      emitted_in  = emitted_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      axis_in     = axis_ff;
      pix_in      = pix_ff;
      piy_in      = piy_ff;
      piz_in      = piz_ff;
      ax_in       = ax_ff;
      ay_in       = ay_ff;
      az_in       = az_ff;
      neg_in      = neg_ff;
      cdsq_in     = cdsq_ff;
      acc_in      = acc_ff;
      len_in      = len_ff;
      nx_in       = nx_ff;
      ny_in       = ny_ff;
      nz_in       = nz_ff;
      pend_v_in   = pend_v_ff;
      pend_i_in   = pend_i_ff;
      pend_j_in   = pend_j_ff;
      pend_nx_in  = pend_nx_ff;
      pend_ny_in  = pend_ny_ff;
      pend_nz_in  = pend_nz_ff;
      pend_pen_in = pend_pen_ff;
      mul_a       = ax_ff;
      mul_b       = ax_ff;
      ucmd.start  = 1'b0;
      ucmd.op     = ppcf_pkg::OP_DIV;
      emit        = 1'b0;
      emit_last   = 1'b0;

      if (csr_wr_en) begin
         case (csr_index)
            ppcf_pkg::CSR_CONTACT_LIMIT:    limit_in = csr_wr_data[ppcf_pkg::LIM_W-1:0];
            ppcf_pkg::CSR_CONTACT_DISTANCE: cd_in    = csr_wr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ppcf_pkg::ST_IDLE: begin
            if (start) begin
               if (wr_en) begin
                  loaded_in = loaded_ff + 1'b1;
               end
               if (req_last_particle) begin
                  state_in = ppcf_pkg::ST_SETUP;
               end
            end
         end
         ppcf_pkg::ST_SETUP: begin
            mul_a   = cd_ff;
            mul_b   = cd_ff;
            cdsq_in = (ppcf_pkg::SQ_W-1)'(prod);
            if (limit_ff == '0) begin
               lim_in = ppcf_pkg::LIM_W'(1);
            end else if (limit_ff > ppcf_pkg::LIMIT_RESET) begin
               lim_in = ppcf_pkg::LIMIT_RESET;
            end else begin
               lim_in = limit_ff;
            end
            emitted_in = '0;
            pend_v_in  = 1'b0;
            i_in       = '0;
            j_in       = '0;
            state_in   = ppcf_pkg::ST_RD_I;
         end
         ppcf_pkg::ST_RD_I: begin
            state_in = ppcf_pkg::ST_LATCH_I;
         end
         ppcf_pkg::ST_LATCH_I: begin
            pix_in   = qx;
            piy_in   = qy;
            piz_in   = qz;
            state_in = ppcf_pkg::ST_RD_J;
         end
         ppcf_pkg::ST_RD_J: begin
            state_in = ppcf_pkg::ST_CHECK;
         end
         ppcf_pkg::ST_CHECK: begin
            ax_in  = abx[ppcf_pkg::CD_W-1:0];
            ay_in  = aby[ppcf_pkg::CD_W-1:0];
            az_in  = abz[ppcf_pkg::CD_W-1:0];
            neg_in = {dz[ppcf_pkg::POS_W], dy[ppcf_pkg::POS_W], dx[ppcf_pkg::POS_W]};
            if (abx >= (ppcf_pkg::POS_W+1)'(cd_ff) || aby >= (ppcf_pkg::POS_W+1)'(cd_ff) ||
                abz >= (ppcf_pkg::POS_W+1)'(cd_ff)) begin
               state_in = ppcf_pkg::ST_NEXT;
            end else begin
               state_in = ppcf_pkg::ST_SQ_X;
            end
         end
         ppcf_pkg::ST_SQ_X: begin
            acc_in   = ppcf_pkg::SQ_W'(prod);
            state_in = ppcf_pkg::ST_SQ_Y;
         end
         ppcf_pkg::ST_SQ_Y: begin
            mul_a    = ay_ff;
            mul_b    = ay_ff;
            acc_in   = acc_ff + ppcf_pkg::SQ_W'(prod);
            state_in = ppcf_pkg::ST_SQ_Z;
         end
         ppcf_pkg::ST_SQ_Z: begin
            mul_a    = az_ff;
            mul_b    = az_ff;
            acc_in   = acc_ff + ppcf_pkg::SQ_W'(prod);
            state_in = ppcf_pkg::ST_RANGE;
         end
         ppcf_pkg::ST_RANGE: begin
            if (acc_ff == '0 || acc_ff >= ppcf_pkg::SQ_W'(cdsq_ff)) begin
               state_in = ppcf_pkg::ST_NEXT;
            end else begin
               ucmd.start = 1'b1;
               ucmd.op    = ppcf_pkg::OP_SQRT;
               state_in   = ppcf_pkg::ST_SQRT;
            end
         end
         ppcf_pkg::ST_SQRT: begin
            if (u_done) begin
               len_in     = u_result;
               axis_in    = 2'd0;
               ucmd.start = 1'b1;
               state_in   = ppcf_pkg::ST_DIV;
            end
         end
         ppcf_pkg::ST_DIV: begin
            if (u_done) begin
               case (axis_ff)
                  2'd0:    nx_in = nrm;
                  2'd1:    ny_in = nrm;
                  default: nz_in = nrm;
               endcase
               if (axis_ff == 2'd2) begin
                  state_in = ppcf_pkg::ST_FOUND;
               end else begin
                  axis_in    = axis_ff + 2'd1;
                  ucmd.start = 1'b1;
               end
            end
         end
         ppcf_pkg::ST_FOUND: begin
            emit        = pend_v_ff;
            pend_v_in   = 1'b1;
            pend_i_in   = ppcf_pkg::IDXO_W'(i_ff);
            pend_j_in   = ppcf_pkg::IDXO_W'(j_ff);
            pend_nx_in  = nx_ff;
            pend_ny_in  = ny_ff;
            pend_nz_in  = nz_ff;
            pend_pen_in = cd_ff - ppcf_pkg::CD_W'(len_ff);
            emitted_in  = emitted_ff + 1'b1;
            if (emitted_in == lim_ff) begin
               state_in = ppcf_pkg::ST_FINISH;
            end else begin
               state_in = ppcf_pkg::ST_NEXT;
            end
         end
         ppcf_pkg::ST_NEXT: begin
            if (last_j) begin
               j_in = '0;
               if (last_i) begin
                  state_in = ppcf_pkg::ST_FINISH;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ppcf_pkg::ST_RD_I;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ppcf_pkg::ST_RD_J;
            end
         end
         ppcf_pkg::ST_FINISH: begin
            emit      = 1'b1;
            emit_last = 1'b1;
            pend_v_in = 1'b0;
            loaded_in = '0;
            state_in  = ppcf_pkg::ST_IDLE;
         end
         default: begin
            state_in = ppcf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ppcf_pkg::ST_IDLE;
         limit_ff   <= ppcf_pkg::LIMIT_RESET;
         cd_ff      <= ppcf_pkg::DISTANCE_RESET;
         loaded_ff  <= '0;
         emitted_ff <= '0;
         pend_v_ff  <= 1'b0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         limit_ff   <= limit_in;
         cd_ff      <= cd_in;
         loaded_ff  <= loaded_in;
         emitted_ff <= emitted_in;
         pend_v_ff  <= pend_v_in;
         rsp_strobe <= emit;
      end
      lim_ff      <= lim_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      axis_ff     <= axis_in;
      pix_ff      <= pix_in;
      piy_ff      <= piy_in;
      piz_ff      <= piz_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      neg_ff      <= neg_in;
      cdsq_ff     <= cdsq_in;
      acc_ff      <= acc_in;
      len_ff      <= len_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      nz_ff       <= nz_in;
      pend_i_ff   <= pend_i_in;
      pend_j_ff   <= pend_j_in;
      pend_nx_ff  <= pend_nx_in;
      pend_ny_ff  <= pend_ny_in;
      pend_nz_ff  <= pend_nz_in;
      pend_pen_ff <= pend_pen_in;
      if (emit) begin
         // no contact held at the end means the lone empty marker
         rsp_contact_valid     <= pend_v_ff;
         rsp_first_index       <= pend_v_ff ? pend_i_ff : '0;
         rsp_second_index      <= pend_v_ff ? pend_j_ff : '0;
         rsp_normal_x          <= pend_v_ff ? pend_nx_ff : '0;
         rsp_normal_y          <= pend_v_ff ? pend_ny_ff : '0;
         rsp_normal_z          <= pend_v_ff ? pend_nz_ff : '0;
         rsp_penetration_depth <= pend_v_ff ? pend_pen_ff : '0;
         rsp_last_contact      <= emit_last;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ppcf_ram.sv @@
// ppcf_ram: generic single write port, single read port RAM with
// registered read data. No dependencies.
`default_nettype none

module ppcf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/ppcf_unit.sv @@
// ppcf_unit: iterative square root and restoring divider built around one
// shared compare-subtract. Depends on ppcf_pkg.
`default_nettype none

module ppcf_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ppcf_pkg::ppcf_unit_cmd_type cmd,
   input  wire logic [ppcf_pkg::SQ_W-1:0]   radicand,
   input  wire logic [ppcf_pkg::CD_W-1:0]   dividend,
   input  wire logic [ppcf_pkg::ROOT_W-1:0] divisor,
   output logic                             done,
   output logic      [ppcf_pkg::ROOT_W-1:0] result
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   ppcf_pkg::ppcf_op_type          op_ff, op_in;
   logic [ppcf_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [ppcf_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [ppcf_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [ppcf_pkg::SQ_W-1:0]      src_ff, src_in;
   logic [ppcf_pkg::ROOT_W-1:0]    div_ff, div_in;

   logic [ppcf_pkg::REM_W-1:0]     cand;
   logic [ppcf_pkg::REM_W-1:0]     trial;
   logic [ppcf_pkg::REM_W:0]       diff;

   always_comb begin
      if (op_ff == ppcf_pkg::OP_SQRT) begin
         cand  = {rem_ff[ppcf_pkg::REM_W-3:0], src_ff[ppcf_pkg::SQ_W-1 -: 2]};
         trial = {root_ff, 2'b01};
      end else begin
         cand  = {rem_ff[ppcf_pkg::REM_W-2:0], src_ff[ppcf_pkg::SQ_W-1]};
         trial = {2'b00, div_ff};
      end
      diff = {1'b0, cand} - {1'b0, trial};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      src_in  = src_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         root_in = '0;
         div_in  = divisor;
         if (cmd.op == ppcf_pkg::OP_SQRT) begin
            cnt_in = ppcf_pkg::STEP_W'(ppcf_pkg::SQRT_STEPS);
            rem_in = '0;
            src_in = radicand;
         end else begin
            // quotient fits FRAC_BITS+1 bits, so the top of the dividend seeds the remainder
            cnt_in = ppcf_pkg::STEP_W'(ppcf_pkg::DIV_STEPS);
            rem_in = ppcf_pkg::REM_W'(dividend >> 1);
            src_in = {dividend[0], (ppcf_pkg::SQ_W-1)'(0)};
         end
      end else if (busy_ff) begin
         if (!diff[ppcf_pkg::REM_W]) begin
            rem_in  = diff[ppcf_pkg::REM_W-1:0];
            root_in = {root_ff[ppcf_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cand;
            root_in = {root_ff[ppcf_pkg::ROOT_W-2:0], 1'b0};
         end
         if (op_ff == ppcf_pkg::OP_SQRT) begin
            src_in = {src_ff[ppcf_pkg::SQ_W-3:0], 2'b00};
         end else begin
            src_in = {src_ff[ppcf_pkg::SQ_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == ppcf_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      src_ff  <= src_in;
      div_ff  <= div_in;
   end

   assign done   = done_ff;
   assign result = root_ff;

endmodule

`default_nettype wire
